// ----- hw/rtl/selective_cpu_dispatch_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// selective_cpu_dispatch_scheduler_defines
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_CPU_DISPATCH_SCHEDULER_DEFINES_SVH
`define SELECTIVE_CPU_DISPATCH_SCHEDULER_DEFINES_SVH

// An implication that must hold at every edge outside reset.
`define SCDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define SCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/scds_pkg.sv -----
// ----------------------------------------------------------------------------
// scds_pkg
// Types and constants shared by the dispatch scheduler files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scds_pkg;

    localparam int MAX_PROCESSES_DEF = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] KIND_RUN    = 2'd0;
    localparam logic [1:0] KIND_IDLE   = 2'd1;
    localparam logic [1:0] KIND_SWITCH = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_PREEMPT = 2'd1;
    localparam logic [1:0] REG_SWCOST  = 2'd2;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_SRTF = 2'd2;
    localparam logic [1:0] POL_PRIO = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] process_id;
        logic [31:0] arrival_time;
        logic [31:0] burst_time;
        logic [15:0] priority_level;
    } item_t;

    typedef struct packed {
        logic [1:0]  slice_kind;
        logic [15:0] slice_process_id;
        logic [31:0] slice_start;
        logic [31:0] slice_end;
        logic        process_finished;
        logic        all_finished;
        logic [15:0] switch_count;
        logic [1:0]  status;
        logic        last;
    } slice_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scds_stream_if.sv -----
// ----------------------------------------------------------------------------
// scds_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scds_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/selective_cpu_dispatch_scheduler.sv -----
// ----------------------------------------------------------------------------
// selective_cpu_dispatch_scheduler
// Process table with a policy-driven dispatcher, one shared compare unit.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  in_ch     | sink      | operation, process_id, arrival/burst time, priority
//  out_ch    | source    | slice kind, id, start, end, flags, count, status
//  cfg_*     | write     | policy_mode, preempt_enable, switch_cost
//
// Clear and load each return a single result beat.
// A dispatch step scans the table up to twice, one entry per cycle
// through the single compare unit and table read port.
// Up to three result beats are issued one per cycle; a stall on out_ch holds.
// Reset is asynchronous, active low; table contents are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module selective_cpu_dispatch_scheduler
#(
    parameter int MAX_PROCESSES = scds_pkg::MAX_PROCESSES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    scds_stream_if.sink            in_ch,
    scds_stream_if.source          out_ch
);
    import scds_pkg::*;

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN1 = 4'd1;
    localparam logic [3:0] S_EVAL1 = 4'd2;
    localparam logic [3:0] S_SCAN2 = 4'd3;
    localparam logic [3:0] S_EVAL2 = 4'd4;
    localparam logic [3:0] S_RUN   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;

    // Table memory, one read port with registered data.
    logic [15:0] mem_id   [MAX_PROCESSES];
    logic [31:0] mem_arr  [MAX_PROCESSES];
    logic [31:0] mem_bur  [MAX_PROCESSES];
    logic [15:0] mem_pri  [MAX_PROCESSES];
    logic [31:0] mem_rem  [MAX_PROCESSES];

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wrem;
    logic          mem_wfull;
    logic [IW-1:0] rd_addr;
    logic [15:0]   rd_id;
    logic [31:0]   rd_arr, rd_bur, rd_rem;
    logic [15:0]   rd_pri;

    logic [3:0]    state_reg;
    logic [1:0]    policy_reg;
    logic          preempt_reg;
    logic [31:0]   swcost_reg;
    logic [CW-1:0] count_reg, fin_reg;
    logic [31:0]   time_reg;
    logic          last_v_reg;
    logic [IW-1:0] last_sel_reg;
    logic          open_v_reg, open_done_reg;
    logic [15:0]   open_pid_reg;
    logic [31:0]   open_start_reg, open_end_reg;
    logic [15:0]   sw_reg;
    logic [1:0]    status_reg;

    // Scan bookkeeping.
    logic [CW-1:0] idx_reg;
    logic          scan_v_reg;
    logic [IW-1:0] scan_i_reg;
    logic          best_v_reg;
    logic [IW-1:0] best_i_reg;
    logic [15:0]   best_id_reg, best_pri_reg;
    logic [31:0]   best_arr_reg, best_bur_reg, best_rem_reg;
    logic          hn_reg;
    logic [31:0]   nx_reg;
    logic [31:0]   now_reg;
    logic          sw_flag_reg;
    logic [31:0]   dur_reg;

    // Result queue of up to three beats.
    slice_t        q_reg [3];
    logic [1:0]    qn_reg, qp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (mem_wfull)
            begin
                mem_id[mem_waddr]  <= in_ch.payload.process_id;
                mem_arr[mem_waddr] <= in_ch.payload.arrival_time;
                mem_bur[mem_waddr] <= mem_wrem;
                mem_pri[mem_waddr] <= in_ch.payload.priority_level;
            end
            mem_rem[mem_waddr] <= mem_wrem;
        end
        rd_id  <= mem_id[rd_addr];
        rd_arr <= mem_arr[rd_addr];
        rd_bur <= mem_bur[rd_addr];
        rd_pri <= mem_pri[rd_addr];
        rd_rem <= mem_rem[rd_addr];
    end

    // Shared preference compare: candidate (rd_*) against held best.
    logic prefer;
    always_comb
    begin
        if (policy_reg == POL_SRTF && rd_rem != best_rem_reg)
            prefer = rd_rem < best_rem_reg;
        else if (policy_reg == POL_PRIO && rd_pri != best_pri_reg)
            prefer = rd_pri < best_pri_reg;
        else if (policy_reg == POL_SJF && rd_bur != best_bur_reg)
            prefer = rd_bur < best_bur_reg;
        else if (rd_arr != best_arr_reg)
            prefer = rd_arr < best_arr_reg;
        else
            prefer = rd_id < best_id_reg;
    end

    logic scanning;
    logic done_scan;
    assign scanning  = (state_reg == S_SCAN1) || (state_reg == S_SCAN2);
    assign done_scan = idx_reg >= count_reg;
    assign rd_addr   = (state_reg == S_RUN || state_reg == S_RD) ? best_i_reg
                                                                 : idx_reg[IW-1:0];

    logic [32:0] sum_sw, sum_run;
    assign sum_sw  = {1'b0, now_reg} + {1'b0, swcost_reg};
    assign sum_run = {1'b0, now_reg} + {1'b0, dur_reg};

    logic all_fin;
    assign all_fin = (count_reg != '0) && (fin_reg >= count_reg);

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_EMIT);
    always_comb
    begin
        out_ch.payload              = q_reg[qp_reg];
        out_ch.payload.all_finished = all_fin;
        out_ch.payload.switch_count = sw_reg;
        out_ch.payload.status       = status_reg;
        out_ch.payload.last         = (qp_reg + 2'd1 == qn_reg);
    end

    function automatic slice_t mk(logic [1:0] k, logic [15:0] p, logic [31:0] s,
                                  logic [31:0] e, logic d);
        slice_t r;
        r = '0;
        r.slice_kind = k;
        r.slice_process_id = p;
        r.slice_start = s;
        r.slice_end = e;
        r.process_finished = d;
        return r;
    endfunction

    assign mem_wfull = (state_reg == S_IDLE);
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_i_reg;
        mem_wrem  = best_rem_reg - dur_reg;
        if (state_reg == S_UPD)
            mem_we = 1'b1;
        if (state_reg == S_IDLE)
        begin
            mem_waddr = count_reg[IW-1:0];
            mem_wrem  = (in_ch.payload.burst_time == '0) ? 32'd1
                                                          : in_ch.payload.burst_time;
            mem_we    = in_ch.valid && in_ch.payload.operation == OP_LOAD
                        && count_reg < CW'(MAX_PROCESSES);
        end
    end

    // Sequencer: config writes, decode, two table scans, run bookkeeping and beat issue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_FCFS;
            preempt_reg   <= 1'b0;
            swcost_reg    <= '0;
            count_reg     <= '0;
            fin_reg       <= '0;
            time_reg      <= '0;
            last_v_reg    <= 1'b0;
            open_v_reg    <= 1'b0;
            sw_reg        <= '0;
            status_reg    <= ST_OK;
            qn_reg        <= '0;
            qp_reg        <= '0;
            idx_reg       <= '0;
            scan_v_reg    <= 1'b0;
            best_v_reg    <= 1'b0;
            hn_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLICY:  policy_reg  <= cfg_data[1:0];
                    REG_PREEMPT: preempt_reg <= cfg_data[0];
                    REG_SWCOST:  swcost_reg  <= cfg_data;
                    default:     ;
                endcase
            end
            // Registered read data arrives in the cycle after its address.
            scan_v_reg <= scanning && !done_scan;
            scan_i_reg <= idx_reg[IW-1:0];

            unique case (state_reg)
                S_IDLE:
                begin
                    qp_reg <= 2'd0;
                    if (in_ch.valid)
                    begin
                        unique case (in_ch.payload.operation)
                            OP_CLEAR:
                            begin
                                status_reg <= ST_OK;
                                count_reg  <= '0;
                                fin_reg    <= '0;
                                time_reg   <= '0;
                                last_v_reg <= 1'b0;
                                open_v_reg <= 1'b0;
                                sw_reg     <= '0;
                                q_reg[0]   <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                                qn_reg     <= 2'd1;
                                state_reg  <= S_EMIT;
                            end
                            OP_LOAD:
                            begin
                                if (count_reg < CW'(MAX_PROCESSES))
                                begin
                                    count_reg  <= count_reg + CW'(1);
                                    status_reg <= ST_OK;
                                end
                                else
                                    status_reg <= ST_FULL;
                                q_reg[0]  <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                                qn_reg    <= 2'd1;
                                state_reg <= S_EMIT;
                            end
                            OP_STEP:
                            begin
                                q_reg[0] <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    qn_reg     <= 2'd1;
                                    state_reg  <= S_EMIT;
                                end
                                else if (fin_reg >= count_reg)
                                begin
                                    status_reg <= ST_OK;
                                    qn_reg     <= 2'd1;
                                    state_reg  <= S_EMIT;
                                end
                                else
                                begin
                                    status_reg <= ST_OK;
                                    now_reg    <= time_reg;
                                    idx_reg    <= '0;
                                    best_v_reg <= 1'b0;
                                    hn_reg     <= 1'b0;
                                    nx_reg     <= '1;
                                    state_reg  <= S_SCAN1;
                                end
                            end
                            default:
                            begin
                                status_reg <= ST_OK;
                                q_reg[0]   <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                                qn_reg     <= 2'd1;
                                state_reg  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN1, S_SCAN2:
                begin
                    if (!done_scan)
                        idx_reg <= idx_reg + CW'(1);
                    if (scan_v_reg && rd_rem != '0)
                    begin
                        if (rd_arr > now_reg)
                        begin
                            hn_reg <= 1'b1;
                            if (!hn_reg || rd_arr < nx_reg)
                                nx_reg <= rd_arr;
                        end
                        else if (!best_v_reg || prefer)
                        begin
                            best_v_reg   <= 1'b1;
                            best_i_reg   <= scan_i_reg;
                            best_id_reg  <= rd_id;
                            best_arr_reg <= rd_arr;
                            best_bur_reg <= rd_bur;
                            best_pri_reg <= rd_pri;
                            best_rem_reg <= rd_rem;
                        end
                    end
                    if (done_scan && !scan_v_reg)
                        state_reg <= (state_reg == S_SCAN1) ? S_EVAL1 : S_EVAL2;
                end
                S_EVAL1:
                begin
                    if (!best_v_reg)
                    begin
                        if (!hn_reg)
                        begin
                            qn_reg <= 2'd1;
                        end
                        else
                        begin
                            if (open_v_reg)
                            begin
                                q_reg[0] <= mk(KIND_RUN, open_pid_reg, open_start_reg,
                                               open_end_reg, open_done_reg);
                                q_reg[1] <= mk(KIND_IDLE, '0, now_reg, nx_reg, 1'b0);
                                qn_reg   <= 2'd2;
                            end
                            else
                            begin
                                q_reg[0] <= mk(KIND_IDLE, '0, now_reg, nx_reg, 1'b0);
                                qn_reg   <= 2'd1;
                            end
                            open_v_reg <= 1'b0;
                            time_reg   <= nx_reg;
                            last_v_reg <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        sw_flag_reg <= last_v_reg && last_sel_reg != best_i_reg;
                        if (last_v_reg && last_sel_reg != best_i_reg && swcost_reg != '0)
                        begin
                            if (sum_sw[32])
                            begin
                                status_reg <= ST_OVERFLOW;
                                qn_reg     <= 2'd1;
                                state_reg  <= S_EMIT;
                            end
                            else
                            begin
                                now_reg    <= sum_sw[31:0];
                                dur_reg    <= now_reg;
                                idx_reg    <= '0;
                                best_v_reg <= 1'b0;
                                hn_reg     <= 1'b0;
                                nx_reg     <= '1;
                                state_reg  <= S_SCAN2;
                            end
                        end
                        else
                        begin
                            dur_reg    <= now_reg;
                            idx_reg    <= '0;
                            best_v_reg <= 1'b0;
                            hn_reg     <= 1'b0;
                            nx_reg     <= '1;
                            state_reg  <= S_SCAN2;
                        end
                    end
                end
                S_EVAL2:
                begin
                    // dur_reg holds the step start time t here.
                    if (!best_v_reg)
                    begin
                        qn_reg    <= 2'd1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        q_reg[2] <= mk(KIND_SWITCH, '0, dur_reg, now_reg, 1'b0);
                        if (preempt_reg && hn_reg && nx_reg > now_reg
                            && (nx_reg - now_reg) < best_rem_reg)
                            dur_reg <= nx_reg - now_reg;
                        else
                            dur_reg <= best_rem_reg;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (sum_run[32])
                    begin
                        status_reg <= ST_OVERFLOW;
                        q_reg[0]   <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                        qn_reg     <= 2'd1;
                        state_reg  <= S_EMIT;
                    end
                    else
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    logic [1:0]  n;
                    logic        ov, odone, flush_sw;
                    logic [31:0] ostart, oend;
                    logic [15:0] opid;
                    n = 2'd0;
                    ov = open_v_reg;
                    opid = open_pid_reg;
                    ostart = open_start_reg;
                    oend = open_end_reg;
                    odone = open_done_reg;
                    flush_sw = sw_flag_reg && swcost_reg != '0;
                    if (sw_flag_reg && sw_reg != 16'hFFFF)
                        sw_reg <= sw_reg + 16'd1;
                    if (flush_sw)
                    begin
                        if (ov)
                        begin
                            q_reg[0] <= mk(KIND_RUN, opid, ostart, oend, odone);
                            q_reg[1] <= q_reg[2];
                            n = 2'd2;
                        end
                        else
                        begin
                            q_reg[0] <= q_reg[2];
                            n = 2'd1;
                        end
                        ov = 1'b0;
                    end
                    if (!(ov && opid == rd_id))
                    begin
                        if (ov)
                        begin
                            q_reg[n] <= mk(KIND_RUN, opid, ostart, oend, odone);
                            n = n + 2'd1;
                        end
                        ov = 1'b1;
                        opid = rd_id;
                        ostart = now_reg;
                    end
                    oend = sum_run[31:0];
                    odone = (best_rem_reg == dur_reg);
                    if (odone)
                        fin_reg <= fin_reg + CW'(1);
                    time_reg     <= sum_run[31:0];
                    last_v_reg   <= 1'b1;
                    last_sel_reg <= best_i_reg;
                    if (fin_reg + CW'(odone) >= count_reg)
                    begin
                        q_reg[n] <= mk(KIND_RUN, opid, ostart, oend, odone);
                        n = n + 2'd1;
                        ov = 1'b0;
                    end
                    if (n == 2'd0)
                    begin
                        q_reg[0] <= mk(KIND_NONE, '0, '0, '0, 1'b0);
                        n = 2'd1;
                    end
                    open_v_reg     <= ov;
                    open_pid_reg   <= opid;
                    open_start_reg <= ostart;
                    open_end_reg   <= oend;
                    open_done_reg  <= odone;
                    qn_reg         <= n;
                    state_reg      <= S_EMIT;
                end
                S_RD:
                    state_reg <= S_UPD;
                S_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        if (qp_reg + 2'd1 == qn_reg)
                            state_reg <= S_IDLE;
                        qp_reg <= qp_reg + 2'd1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/scds_checker.sv -----
// ----------------------------------------------------------------------------
// scds_checker
// Port-level checks on the dispatch scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "selective_cpu_dispatch_scheduler_defines.svh"

module scds_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  out_kind,
    input wire logic [1:0]  out_status,
    input wire logic        out_last,
    input wire logic [31:0] out_start,
    input wire logic [31:0] out_end
);
    import scds_pkg::*;

    // The block never takes an item while a result is on offer.
    `SCDS_ASSERT_IMPL(a_excl, clk, rst_n, out_valid, !in_ready, "ready while results pending")
    // An accepted item is followed by no immediate input acceptance.
    `SCDS_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    // A slice never ends before it starts.
    `SCDS_ASSERT_IMPL(a_order, clk, rst_n, out_valid && out_kind != KIND_NONE, out_end >= out_start, "slice ends before start")
    // Error statuses come only with a single no-slice beat.
    `SCDS_ASSERT_IMPL(a_err, clk, rst_n, out_valid && out_status != ST_OK, out_kind == KIND_NONE && out_last, "error with a slice")
endmodule

bind selective_cpu_dispatch_scheduler scds_checker u_scds_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.payload.slice_kind), .out_status(out_ch.payload.status),
    .out_last(out_ch.payload.last), .out_start(out_ch.payload.slice_start),
    .out_end(out_ch.payload.slice_end)
);

`default_nettype wire
